// ===== hdl/dtd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared types and constants for the differential track drive timeout unit.
// ----------------------------------------------------------------------------
package dtd_pkg;

  localparam int unsigned DutyBitsDefault = 10;
  localparam int unsigned PctScale        = 100;
  localparam int unsigned MagBits         = 7;
  localparam int unsigned SpeedBits       = 8;
  localparam int unsigned MsBits          = 16;
  localparam logic [MsBits-1:0] MaxDurationReset = 16'd30000;
  localparam logic signed [SpeedBits-1:0] SpeedLimit = 8'sd100;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_STOP = 2'd1,
    OP_TICK = 2'd2
  } opcode_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_INV_ARG = 1'b1
  } status_e;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [SpeedBits-1:0] left_speed;
    logic signed [SpeedBits-1:0] right_speed;
    logic [MsBits-1:0]           run_ms;
  } request_t;

endpackage

// ===== hdl/differential_track_drive_timeout_unit.sv =====
// ----------------------------------------------------------------------------
// differential_track_drive_timeout_unit
// Two-sided H-bridge drive with signed percent speeds and a millisecond
// run timeout.
// ----------------------------------------------------------------------------
// Requests (set, stop, tick) arrive on the in_* valid/ready channel; each
// request yields exactly one result on the out_* valid/ready channel showing
// status, bridge enable, the four PWM duties and the expiry flag after it.
// A request is captured in an input register and then applied to the drive
// state while its result is loaded into the result register: out_valid_o
// rises on the edge that applies it, and one request is taken every cycle
// while the receiver keeps up. When it stalls, the result register holds
// and the input register fills; in_ready_o drops only while both are full.
// The cfg_* channel writes the largest accepted run duration and is always
// ready; users write it only while no request is in flight, unchecked.
// Reset clears the duties, the bridge enable, the countdown and both
// pipeline valids, and loads the duration limit with 30000 ms.
// ----------------------------------------------------------------------------
module differential_track_drive_timeout_unit #(
  parameter int unsigned DUTY_BITS = dtd_pkg::DutyBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             opcode_i,
  input  logic signed [dtd_pkg::SpeedBits-1:0]   left_speed_i,
  input  logic signed [dtd_pkg::SpeedBits-1:0]   right_speed_i,
  input  logic [dtd_pkg::MsBits-1:0]             run_ms_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dtd_pkg::MsBits-1:0]             cfg_max_duration_ms_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   status_o,
  output logic                                   bridge_enable_o,
  output logic [DUTY_BITS-1:0]                   left_reverse_duty_o,
  output logic [DUTY_BITS-1:0]                   left_forward_duty_o,
  output logic [DUTY_BITS-1:0]                   right_reverse_duty_o,
  output logic [DUTY_BITS-1:0]                   right_forward_duty_o,
  output logic                                   drive_expired_o
);

  localparam int unsigned DutyMax = (1 << DUTY_BITS) - 1;
  localparam int unsigned LutSize = 1 << dtd_pkg::MagBits;
  localparam int unsigned NumCh   = 4;
  localparam int unsigned ChLRev  = 0;
  localparam int unsigned ChLFwd  = 1;
  localparam int unsigned ChRRev  = 2;
  localparam int unsigned ChRFwd  = 3;

  logic [DUTY_BITS-1:0] duty_lut [LutSize];

  for (genvar m = 0; m < LutSize; m++) begin : g_lut
    localparam int unsigned Entry = (m * DutyMax) / dtd_pkg::PctScale;
    assign duty_lut[m] = DUTY_BITS'(Entry);
  end

  logic                          req_valid_q;
  dtd_pkg::request_t             req_q;
  logic                          advance;

  logic [dtd_pkg::MsBits-1:0]    max_ms_q;

  logic [DUTY_BITS-1:0]          duty_q [NumCh];
  logic [DUTY_BITS-1:0]          duty_d [NumCh];
  logic                          enabled_q, enabled_d;
  logic [dtd_pkg::MsBits-1:0]    remaining_q, remaining_d;
  logic                          status_d, expired_d;

  logic                          res_valid_q;
  logic                          res_status_q, res_enable_q, res_expired_q;
  logic [DUTY_BITS-1:0]          res_duty_q [NumCh];

  logic [dtd_pkg::SpeedBits-1:0] left_abs, right_abs;
  logic [DUTY_BITS-1:0]          left_duty, right_duty;
  logic                          speed_bad;

  assign advance     = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o  = !req_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ms_q <= dtd_pkg::MaxDurationReset;
    end else if (cfg_valid_i) begin
      max_ms_q <= cfg_max_duration_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.opcode      <= opcode_i;
      req_q.left_speed  <= left_speed_i;
      req_q.right_speed <= right_speed_i;
      req_q.run_ms      <= run_ms_i;
    end
  end

  assign left_abs   = req_q.left_speed[dtd_pkg::SpeedBits-1]
                      ? dtd_pkg::SpeedBits'(-req_q.left_speed)
                      : dtd_pkg::SpeedBits'(req_q.left_speed);
  assign right_abs  = req_q.right_speed[dtd_pkg::SpeedBits-1]
                      ? dtd_pkg::SpeedBits'(-req_q.right_speed)
                      : dtd_pkg::SpeedBits'(req_q.right_speed);
  assign left_duty  = duty_lut[left_abs[dtd_pkg::MagBits-1:0]];
  assign right_duty = duty_lut[right_abs[dtd_pkg::MagBits-1:0]];
  assign speed_bad  = (req_q.left_speed > dtd_pkg::SpeedLimit)
                   || (req_q.left_speed < -dtd_pkg::SpeedLimit)
                   || (req_q.right_speed > dtd_pkg::SpeedLimit)
                   || (req_q.right_speed < -dtd_pkg::SpeedLimit);

  always_comb begin
    duty_d      = duty_q;
    enabled_d   = enabled_q;
    remaining_d = remaining_q;
    status_d    = dtd_pkg::STATUS_OK;
    expired_d   = 1'b0;
    unique case (req_q.opcode)
      dtd_pkg::OP_SET: begin
        if (speed_bad || (req_q.run_ms > max_ms_q)) begin
          status_d = dtd_pkg::STATUS_INV_ARG;
        end else begin
          for (int i = 0; i < NumCh; i++) duty_d[i] = '0;
          enabled_d   = 1'b0;
          remaining_d = '0;
          if ((req_q.run_ms != '0) &&
              ((req_q.left_speed != '0) || (req_q.right_speed != '0))) begin
            if (req_q.left_speed > 0) duty_d[ChLFwd] = left_duty;
            if (req_q.left_speed < 0) duty_d[ChLRev] = left_duty;
            if (req_q.right_speed > 0) duty_d[ChRFwd] = right_duty;
            if (req_q.right_speed < 0) duty_d[ChRRev] = right_duty;
            enabled_d   = 1'b1;
            remaining_d = req_q.run_ms;
          end
        end
      end
      dtd_pkg::OP_STOP: begin
        for (int i = 0; i < NumCh; i++) duty_d[i] = '0;
        enabled_d   = 1'b0;
        remaining_d = '0;
      end
      dtd_pkg::OP_TICK: begin
        if (remaining_q != '0) begin
          remaining_d = remaining_q - 1'b1;
          if (remaining_q == dtd_pkg::MsBits'(1)) begin
            for (int i = 0; i < NumCh; i++) duty_d[i] = '0;
            enabled_d = 1'b0;
            expired_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) duty_q[i] <= '0;
      enabled_q   <= 1'b0;
      remaining_q <= '0;
    end else if (advance) begin
      duty_q      <= duty_d;
      enabled_q   <= enabled_d;
      remaining_q <= remaining_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || out_ready_i) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_status_q  <= status_d;
      res_enable_q  <= enabled_d;
      res_expired_q <= expired_d;
      res_duty_q    <= duty_d;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign status_o             = res_status_q;
  assign bridge_enable_o      = res_enable_q;
  assign drive_expired_o      = res_expired_q;
  assign left_reverse_duty_o  = res_duty_q[ChLRev];
  assign left_forward_duty_o  = res_duty_q[ChLFwd];
  assign right_reverse_duty_o = res_duty_q[ChRRev];
  assign right_forward_duty_o = res_duty_q[ChRFwd];

endmodule
